### hw/rtl/fpit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpit_pkg
// Shared types and constants for the first-parent inclusion test block.
// ----------------------------------------------------------------------------
package fpit_pkg;
  localparam int ITEM_COUNT    = 256;
  localparam int LIST_CAPACITY = 64;
  localparam int TID_BITS      = 16;
  localparam int ITEM_W        = $clog2(ITEM_COUNT);
  localparam int POS_W         = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int LEN_W         = $clog2(LIST_CAPACITY + 1);
  localparam int TID_ADDR_W    = ITEM_W + POS_W;
  localparam int SUP_W         = 16;

  typedef enum logic [1:0] {
    MODE_SUPPORT = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QSUP,
    ST_PICK,
    ST_CSUP,
    ST_MRD,
    ST_MCMP,
    ST_DONE,
    ST_CLR
  } state_t;

  localparam logic [0:0] REG_MAX_FREQ = 1'b0;
endpackage
`default_nettype wire

### hw/rtl/fpit_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpit_in_if / fpit_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface fpit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  item;
  logic [15:0] value;
  modport source (output valid, mode, item, value, input ready);
  modport sink   (input valid, mode, item, value, output ready);
endinterface

interface fpit_out_if;
  logic       valid;
  logic       ready;
  logic       rejected;
  logic [7:0] parent_item;
  logic       overflow;
  modport source (output valid, rejected, parent_item, overflow, input ready);
  modport sink   (input valid, rejected, parent_item, overflow, output ready);
endinterface
`default_nettype wire

### hw/rtl/fpit_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpit_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fpit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hw/rtl/first_parent_inclusion_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_parent_inclusion_test
// Load/query engine over per-item supports and sorted transaction id lists.
// ----------------------------------------------------------------------------
// After reset the block zeroes every entry of the list-length memory; the input
// is not ready during that pass. Loads (set support, append id, clear list)
// pass through ST_QSUP and are then delivered. A query scans candidate items
// and merges their id lists with the queried item's list; the single-port id
// memory is read once per merge step. Supports, ids and list lengths all live
// in RAMs with a registered read.
module first_parent_inclusion_test
  import fpit_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  fpit_in_if.sink          in_ch,
  fpit_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  state_t state_r, state_nxt;
  logic [ITEM_W-1:0] maxf_r;
  logic [ITEM_W-1:0] clr_r;
  logic [1:0]  mode_r;
  logic [ITEM_W-1:0] item_r, scan_r, scan_nxt;
  logic [15:0] value_r;
  logic [SUP_W-1:0] csup_r;
  logic [LEN_W-1:0] na_r, nb_r;
  logic [LEN_W-1:0] i_r, j_r, i_nxt, j_nxt;
  logic [TID_BITS-1:0] a_r;
  logic phase_r, phase_nxt;
  logic out_valid_r, rej_r, ovf_r;
  logic [7:0] par_r;

  // memories
  logic sup_we, tid_we, len_we;
  logic [ITEM_W-1:0] sup_addr, len_addr;
  logic [TID_ADDR_W-1:0] tid_addr;
  logic [SUP_W-1:0] sup_rd;
  logic [TID_BITS-1:0] tid_rd;
  logic [LEN_W-1:0] len_wdata, len_rd;

  fpit_ram #(.WIDTH(SUP_W), .DEPTH(ITEM_COUNT)) u_sup (
    .clk(clk), .we(sup_we), .addr(sup_addr), .wdata(value_r), .rdata(sup_rd));
  fpit_ram #(.WIDTH(TID_BITS), .DEPTH(ITEM_COUNT*LIST_CAPACITY)) u_tid (
    .clk(clk), .we(tid_we), .addr(tid_addr),
    .wdata(TID_BITS'(value_r)), .rdata(tid_rd));
  fpit_ram #(.WIDTH(LEN_W), .DEPTH(ITEM_COUNT)) u_len (
    .clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wdata), .rdata(len_rd));

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_FREQ) ? {24'd0, maxf_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxf_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MAX_FREQ) begin
      maxf_r <= cfg_pwdata[ITEM_W-1:0];
    end
  end

  logic in_fire, out_fire;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // next state
  logic found, fail, fin;
  always_comb begin
    state_nxt = state_r;
    scan_nxt = scan_r;
    i_nxt = i_r;
    j_nxt = j_r;
    phase_nxt = phase_r;
    found = 1'b0;
    fail = 1'b0;
    fin = 1'b0;
    unique case (state_r)
      ST_CLR: if (clr_r == ITEM_W'(ITEM_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) state_nxt = ST_QSUP;
      ST_QSUP: begin
        if (mode_r != MODE_QUERY) begin
          fin = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = maxf_r;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (scan_r <= item_r) begin
          fin = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CSUP;
        end
      end
      ST_CSUP: begin
        i_nxt = '0;
        j_nxt = '0;
        phase_nxt = 1'b0;
        if (sup_rd < csup_r) begin
          scan_nxt = scan_r - 1'b1;
          state_nxt = ST_PICK;
        end else if (na_r == '0) begin
          found = 1'b1;
        end else begin
          state_nxt = ST_MRD;
        end
      end
      ST_MRD: state_nxt = ST_MCMP;
      ST_MCMP: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = ST_MRD;
        end else if (j_r >= nb_r) begin
          fail = 1'b1;
        end else if (tid_rd < a_r) begin
          j_nxt = j_r + 1'b1;
          state_nxt = ST_MRD;
        end else if (tid_rd != a_r) begin
          fail = 1'b1;
        end else if (i_r + 1'b1 == na_r) begin
          found = 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
          j_nxt = j_r + 1'b1;
          phase_nxt = 1'b0;
          state_nxt = ST_MRD;
        end
        if (fail) begin
          scan_nxt = scan_r - 1'b1;
          state_nxt = ST_PICK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (found) begin
      fin = 1'b1;
      state_nxt = ST_IDLE;
    end
  end

  // memory control
  always_comb begin
    sup_we = 1'b0;
    tid_we = 1'b0;
    len_we = 1'b0;
    sup_addr = item_r;
    len_addr = item_r;
    len_wdata = '0;
    tid_addr = {item_r, len_rd[POS_W-1:0]};
    unique case (state_r)
      // zero one list length per cycle after reset
      ST_CLR: begin
        len_we = 1'b1;
        len_addr = clr_r;
      end
      // read the incoming item so its data is ready in the next cycle
      ST_IDLE: begin
        sup_addr = in_ch.item;
        len_addr = in_ch.item;
      end
      ST_QSUP: begin
        sup_we = (mode_r == MODE_SUPPORT);
        tid_we = (mode_r == MODE_APPEND) && (len_rd < LEN_W'(LIST_CAPACITY));
        if (mode_r == MODE_APPEND && len_rd < LEN_W'(LIST_CAPACITY)) begin
          len_we = 1'b1;
          len_wdata = len_rd + 1'b1;
        end else if (mode_r == MODE_CLEAR) begin
          len_we = 1'b1;
        end
      end
      ST_PICK: begin
        sup_addr = scan_r;
        len_addr = scan_r;
      end
      ST_MRD: tid_addr = phase_r ? {scan_r, j_r[POS_W-1:0]} : {item_r, i_r[POS_W-1:0]};
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (fin) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      item_r <= in_ch.item;
      value_r <= in_ch.value;
    end
    if (state_r == ST_QSUP) begin
      csup_r <= sup_rd;
      na_r <= len_rd;
    end
    if (state_r == ST_CSUP) nb_r <= len_rd;
    if (state_r == ST_MCMP && !phase_r) a_r <= tid_rd;
    scan_r <= scan_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    phase_r <= phase_nxt;
    if (fin) begin
      rej_r <= found;
      par_r <= found ? 8'(scan_r) : 8'd0;
      ovf_r <= (state_r == ST_QSUP) && (mode_r == MODE_APPEND) &&
               (len_rd >= LEN_W'(LIST_CAPACITY));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rejected = rej_r;
  assign out_ch.parent_item = par_r;
  assign out_ch.overflow = ovf_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready) else $error("accept while busy");
  a_rej_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (mode_r == MODE_QUERY)) else $error("reject on load");
  a_parent_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (par_r > 8'(item_r))) else $error("parent not above");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result dropped");
endmodule
`default_nettype wire
